// ===== rtl/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16LE / 8-bit string to UTF-8 block.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] NEWLINE   = 8'h0A;
    localparam logic [7:0] PFX_CONT  = 8'h80;
    localparam logic [7:0] PFX_TWO   = 8'hC0;
    localparam logic [7:0] PFX_THREE = 8'hE0;

    // byte position within a value
    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_LATER  = 3'b100
    } t_pos;

    // one queued item: up to three output bytes, bytes[0] goes first
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            bare;
        logic            last;
    } t_cmd;

endpackage

// ===== rtl/utf16le_string_list_to_utf8.sv =====
// ----------------------------------------------------------------------------
// utf16le_string_list_to_utf8
// Converts a stored string value (UTF-16LE or 8-bit text) to UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input channel: one raw byte per item (i_data_byte, i_last_byte on the
// final byte), valid/ready. Output channel: one UTF-8 byte per item with
// o_byte_valid (0 for a bare end marker) and o_end_of_value on the final
// result of a value. i_cfg_we/i_cfg_data write list_mode (0 single string,
// 1 null-separated list); user's duty, unchecked: only while the block is idle.
// The front accepts one byte per cycle whenever the queue has room and
// classifies it into a group of 0 to 3 output bytes; groups go into a
// FIFO_DEPTH-entry queue. The back drains one byte per cycle while the
// receiver is ready, so a byte that makes one output byte sustains 1
// item/cycle. Each group is registered in the queue before it reaches
// the output. Bytes that make no output (the held first byte, a UTF-16
// low byte) never enter the queue, except a last byte, which queues a
// bare end marker.
// Synchronous reset empties the queue, clears decode state and sets
// list_mode to 0. When the receiver stalls the output holds and the queue
// fills; o_in_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module utf16le_string_list_to_utf8 #(
    parameter int FIFO_DEPTH = u16u8_pkg::FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_value
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    u16u8_pkg::t_cmd cmd;
    u16u8_pkg::t_cmd head;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    u16u8_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    u16u8_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_end_of_value (o_end_of_value)
    );

endmodule

// ===== rtl/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts input bytes, tracks encoding and list state, and turns each item
// with output or a last byte into a queue entry of up to three UTF-8 bytes.
// ----------------------------------------------------------------------------
module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_q_full,
    output logic              o_push,
    output u16u8_pkg::t_cmd   o_cmd
);

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            stopped;
        logic            emitted_any;
        logic            last_nl;
        logic            prev_null;
        logic            str_start;
    } t_emit;

    function automatic t_emit put_byte(t_emit e, logic [7:0] b);
        t_emit r;
        r = e;
        if (r.cnt != 2'd3) begin
            r.bytes[r.cnt] = b;
            r.cnt          = r.cnt + 2'd1;
        end
        r.emitted_any = 1'b1;
        r.last_nl     = (b == u16u8_pkg::NEWLINE);
        return r;
    endfunction

    function automatic t_emit narrow(t_emit e, logic [7:0] b, logic is_last, logic lm);
        t_emit r;
        r = e;
        if (!r.stopped) begin
            if (!lm) begin
                if (b == 8'h00) r.stopped = 1'b1;
                else            r = put_byte(r, b);
            end else if (b == 8'h00) begin
                if (r.str_start) begin
                    r.stopped = 1'b1;
                end else begin
                    r           = put_byte(r, u16u8_pkg::NEWLINE);
                    r.str_start = 1'b1;
                end
            end else begin
                r           = put_byte(r, b);
                r.str_start = 1'b0;
                if (is_last) r = put_byte(r, u16u8_pkg::NEWLINE);
            end
        end
        return r;
    endfunction

    function automatic t_emit wide(t_emit e, logic [15:0] u, logic lm);
        t_emit r;
        r = e;
        if (!r.stopped) begin
            if (u == 16'h0000) begin
                if (!lm || r.prev_null) begin
                    r.stopped = 1'b1;
                end else begin
                    if (r.emitted_any && !r.last_nl) r = put_byte(r, u16u8_pkg::NEWLINE);
                    r.prev_null = 1'b1;
                end
            end else begin
                r.prev_null = 1'b0;
                if (u[15:7] == 9'd0) begin
                    r = put_byte(r, {1'b0, u[6:0]});
                end else if (u[15:11] == 5'd0) begin
                    r = put_byte(r, u16u8_pkg::PFX_TWO | {3'b000, u[10:6]});
                    r = put_byte(r, u16u8_pkg::PFX_CONT | {2'b00, u[5:0]});
                end else begin
                    r = put_byte(r, u16u8_pkg::PFX_THREE | {4'b0000, u[15:12]});
                    r = put_byte(r, u16u8_pkg::PFX_CONT | {2'b00, u[11:6]});
                    r = put_byte(r, u16u8_pkg::PFX_CONT | {2'b00, u[5:0]});
                end
            end
        end
        return r;
    endfunction

    logic              r_list_mode;
    u16u8_pkg::t_pos   r_pos;
    logic [7:0]        r_held;
    logic              r_wide;
    logic [7:0]        r_pend;
    logic              r_half;
    logic              r_stopped;
    logic              r_emitted_any;
    logic              r_last_nl;
    logic              r_prev_null;
    logic              r_str_start;

    u16u8_pkg::t_pos   n_pos;
    logic              n_wide;
    logic              n_half;
    t_emit             e_cur;
    t_emit             e_new;
    logic              accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        e_cur.bytes       = '0;
        e_cur.cnt         = 2'd0;
        e_cur.stopped     = r_stopped;
        e_cur.emitted_any = r_emitted_any;
        e_cur.last_nl     = r_last_nl;
        e_cur.prev_null   = r_prev_null;
        e_cur.str_start   = r_str_start;
        e_new             = e_cur;
        n_pos             = r_pos;
        n_wide            = r_wide;
        n_half            = r_half;
        unique case (r_pos)
            u16u8_pkg::POS_FIRST: begin
                n_pos = u16u8_pkg::POS_SECOND;
                if (i_last_byte) e_new = narrow(e_cur, i_data_byte, 1'b1, r_list_mode);
            end
            u16u8_pkg::POS_SECOND: begin
                n_pos = u16u8_pkg::POS_LATER;
                if (i_data_byte == 8'h00) begin
                    n_wide = 1'b1;
                    e_new  = wide(e_cur, {8'h00, r_held}, r_list_mode);
                end else begin
                    n_wide = 1'b0;
                    e_new  = narrow(e_cur, r_held, 1'b0, r_list_mode);
                    e_new  = narrow(e_new, i_data_byte, i_last_byte, r_list_mode);
                end
            end
            default: begin
                if (r_wide) begin
                    n_half = !r_half;
                    if (r_half) e_new = wide(e_cur, {i_data_byte, r_pend}, r_list_mode);
                end else begin
                    e_new = narrow(e_cur, i_data_byte, i_last_byte, r_list_mode);
                end
            end
        endcase
    end

    always_comb begin
        o_push     = accept && (e_new.cnt != 2'd0 || i_last_byte);
        o_cmd.last = i_last_byte;
        if (e_new.cnt == 2'd0) begin
            o_cmd.bytes = '0;
            o_cmd.cnt   = 2'd1;
            o_cmd.bare  = 1'b1;
        end else begin
            o_cmd.bytes = e_new.bytes;
            o_cmd.cnt   = e_new.cnt;
            o_cmd.bare  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_list_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_byte)) begin
            r_pos         <= u16u8_pkg::POS_FIRST;
            r_held        <= 8'h00;
            r_wide        <= 1'b0;
            r_pend        <= 8'h00;
            r_half        <= 1'b0;
            r_stopped     <= 1'b0;
            r_emitted_any <= 1'b0;
            r_last_nl     <= 1'b0;
            r_prev_null   <= 1'b0;
            r_str_start   <= 1'b1;
        end else if (accept) begin
            r_pos         <= n_pos;
            r_wide        <= n_wide;
            r_half        <= n_half;
            r_stopped     <= e_new.stopped;
            r_emitted_any <= e_new.emitted_any;
            r_last_nl     <= e_new.last_nl;
            r_prev_null   <= e_new.prev_null;
            r_str_start   <= e_new.str_start;
            if (r_pos == u16u8_pkg::POS_FIRST) r_held <= i_data_byte;
            if (r_pos == u16u8_pkg::POS_LATER && r_wide && !r_half) r_pend <= i_data_byte;
        end
    end

endmodule

// ===== rtl/u16u8_fifo.sv =====
// ----------------------------------------------------------------------------
// u16u8_fifo
// Small queue of byte groups between the front and back parts.
// ----------------------------------------------------------------------------
module u16u8_fifo #(
    parameter int DEPTH = u16u8_pkg::FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u16u8_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output u16u8_pkg::t_cmd o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u16u8_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== rtl/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the queue head one byte per cycle onto the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module u16u8_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  u16u8_pkg::t_cmd i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_end_of_value
);

    logic [1:0] r_idx;
    logic       at_end;
    logic       fire;

    assign at_end         = (r_idx == i_head.cnt - 2'd1);
    assign o_out_valid    = !i_q_empty;
    assign o_out_byte     = i_head.bytes[r_idx];
    assign o_byte_valid   = !i_head.bare;
    assign o_end_of_value = i_head.last && at_end;
    assign fire           = o_out_valid && i_out_ready;
    assign o_pop          = fire && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (fire) begin
            r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

// ===== rtl/u16u8_chk.sv =====
// ----------------------------------------------------------------------------
// u16u8_chk
// Port-level checks for the string to UTF-8 converter.
// ----------------------------------------------------------------------------
module u16u8_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_end_of_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_byte_valid)
            && $stable(o_end_of_value))
        else $error("output item changed while stalled");

    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_end_of_value && o_out_byte == 8'h00)
        else $error("bare marker without end flag or with data");

    a_no_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> o_out_byte != 8'h00)
        else $error("null data byte emitted");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("queue not empty after reset");

endmodule

bind utf16le_string_list_to_utf8 u16u8_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_out_byte     (o_out_byte),
    .o_byte_valid   (o_byte_valid),
    .o_end_of_value (o_end_of_value)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf16le_string_list_to_utf8.
// Directed values cover the one-byte value, UTF-16 units at the 1/2/3-byte
// boundaries, a dropped odd trailing byte, and list endings. Random values
// in both modes follow, with random idling on both channels, one long
// receiver hold-off, and a final phase with no idling. An internal decoder
// predicts every output byte.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;

    typedef struct {
        logic [7:0] data;
        logic       bvalid;
        logic       eov;
    } t_utf8_byte;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_we       = 1'b0;
    logic       i_cfg_data     = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_data_byte    = 8'h00;
    logic       i_last_byte    = 1'b0;
    logic       i_out_ready    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_end_of_value;

    t_utf8_byte utf8_expected[$];
    t_utf8_byte step_out[$];
    logic [7:0] value_bytes[$];

    int  errors      = 0;
    int  items_sent  = 0;
    int  stall_cycles = 0;
    int  rx_gap      = 0;
    bit  hold_req    = 1'b0;
    bit  tx_idle_en  = 1'b1;
    bit  rx_idle_en  = 1'b1;

    // decoder state
    bit              m_list;
    u16u8_pkg::t_pos m_pos;
    logic [7:0]      m_first;
    bit              m_wide;
    logic [7:0]      m_low;
    bit              m_half;
    bit              m_done;
    bit              m_any;
    bit              m_nl;
    bit              m_prev_null;
    bit              m_str_start;

    utf16le_string_list_to_utf8 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_end_of_value (o_end_of_value)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_decode();
        m_pos       = u16u8_pkg::POS_FIRST;
        m_first     = 8'h00;
        m_wide      = 1'b0;
        m_low       = 8'h00;
        m_half      = 1'b0;
        m_done      = 1'b0;
        m_any       = 1'b0;
        m_nl        = 1'b0;
        m_prev_null = 1'b0;
        m_str_start = 1'b1;
    endfunction

    function automatic void emit_utf8(logic [7:0] b);
        t_utf8_byte r;
        r.data   = b;
        r.bvalid = 1'b1;
        r.eov    = 1'b0;
        if (step_out.size() < 3)
            step_out.push_back(r);
        m_any = 1'b1;
        m_nl  = (b == u16u8_pkg::NEWLINE);
    endfunction

    function automatic void narrow_char(logic [7:0] b, bit last);
        if (m_done)
            return;
        if (!m_list) begin
            if (b == 8'h00)
                m_done = 1'b1;
            else
                emit_utf8(b);
            return;
        end
        if (b == 8'h00) begin
            if (m_str_start) begin
                m_done = 1'b1;
            end else begin
                emit_utf8(u16u8_pkg::NEWLINE);
                m_str_start = 1'b1;
            end
            return;
        end
        emit_utf8(b);
        m_str_start = 1'b0;
        if (last)
            emit_utf8(u16u8_pkg::NEWLINE);
    endfunction

    function automatic void wide_char(logic [15:0] u);
        if (m_done)
            return;
        if (u == 16'h0000) begin
            if (!m_list || m_prev_null) begin
                m_done = 1'b1;
                return;
            end
            if (m_any && !m_nl)
                emit_utf8(u16u8_pkg::NEWLINE);
            m_prev_null = 1'b1;
            return;
        end
        m_prev_null = 1'b0;
        if (u < 16'h0080) begin
            emit_utf8(u[7:0]);
        end else if (u < 16'h0800) begin
            emit_utf8(u16u8_pkg::PFX_TWO | {3'b000, u[10:6]});
            emit_utf8(u16u8_pkg::PFX_CONT | {2'b00, u[5:0]});
        end else begin
            emit_utf8(u16u8_pkg::PFX_THREE | {4'h0, u[15:12]});
            emit_utf8(u16u8_pkg::PFX_CONT | {2'b00, u[11:6]});
            emit_utf8(u16u8_pkg::PFX_CONT | {2'b00, u[5:0]});
        end
    endfunction

    function automatic void predict_utf8(logic [7:0] b, bit last);
        t_utf8_byte r;
        step_out.delete();
        case (m_pos)
            u16u8_pkg::POS_FIRST: begin
                m_first = b;
                m_pos   = u16u8_pkg::POS_SECOND;
                if (last)
                    narrow_char(b, 1'b1);
            end
            u16u8_pkg::POS_SECOND: begin
                m_pos = u16u8_pkg::POS_LATER;
                if (b == 8'h00) begin
                    m_wide = 1'b1;
                    wide_char({8'h00, m_first});
                end else begin
                    m_wide = 1'b0;
                    narrow_char(m_first, 1'b0);
                    narrow_char(b, last);
                end
            end
            default: begin
                if (m_wide) begin
                    if (!m_half) begin
                        m_low  = b;
                        m_half = 1'b1;
                    end else begin
                        m_half = 1'b0;
                        wide_char({b, m_low});
                    end
                end else begin
                    narrow_char(b, last);
                end
            end
        endcase
        if (last) begin
            if (step_out.size() == 0) begin
                r.data   = 8'h00;
                r.bvalid = 1'b0;
                r.eov    = 1'b1;
            end else begin
                r     = step_out.pop_back();
                r.eov = 1'b1;
            end
            step_out.push_back(r);
            clear_decode();
        end
        foreach (step_out[i])
            utf8_expected.push_back(step_out[i]);
    endfunction

    // receiver: random ready bursts plus an on-request long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            rx_gap   = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (rx_gap == 0 && rx_idle_en && $urandom_range(0, 5) == 0)
            rx_gap = $urandom_range(1, 5);
        if (rx_gap > 0) begin
            i_out_ready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_utf8_byte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (utf8_expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: byte %02h valid %0d end %0d",
                             o_out_byte, o_byte_valid, o_end_of_value);
            end else begin
                want = utf8_expected.pop_front();
                if (o_out_byte !== want.data || o_byte_valid !== want.bvalid ||
                    o_end_of_value !== want.eov) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected byte %02h valid %0d end %0d,",
                                 want.data, want.bvalid, want.eov,
                                 " got byte %02h valid %0d end %0d",
                                 o_out_byte, o_byte_valid, o_end_of_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** utf16le_string_list_to_utf8: FAILED **");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, bit last);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_utf8(b, last);
        items_sent++;
    endtask

    task automatic send_value();
        foreach (value_bytes[i])
            send_byte(value_bytes[i], i == value_bytes.size() - 1);
    endtask

    task automatic set_list_mode(bit mode);
        i_in_valid <= 1'b0;
        while (utf8_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_list = mode;
    endtask

    function automatic void push_unit(logic [15:0] u);
        value_bytes.push_back(u[7:0]);
        value_bytes.push_back(u[15:8]);
    endfunction

    function automatic void build_random_value();
        int kind;
        int n;
        int r;
        logic [7:0] b;
        value_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) value_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 5) begin
            n = $urandom_range(2, 12);
            for (int i = 0; i < n; i++) begin
                b = 8'($urandom_range(1, 255));
                if (i != 1 && $urandom_range(0, 5) == 0)
                    b = 8'h00;
                value_bytes.push_back(b);
            end
        end else begin
            push_unit({8'h00, 8'($urandom_range(0, 255))});
            n = $urandom_range(1, 10);
            repeat (n) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    push_unit(16'h0000);
                else if (r < 4)
                    push_unit(16'($urandom_range(16'h0001, 16'h007F)));
                else if (r < 7)
                    push_unit(16'($urandom_range(16'h0080, 16'h07FF)));
                else
                    push_unit(16'($urandom_range(16'h0800, 16'hFFFF)));
            end
            if ($urandom_range(0, 4) == 0)
                value_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic test_single_string();
        value_bytes = '{8'h41};
        send_value();
        value_bytes = '{8'h48, 8'h00, 8'h78};
        send_value();
    endtask

    task automatic test_utf16_units();
        value_bytes = '{8'h7F, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h07, 8'h00, 8'h08,
                        8'hFF, 8'hFF, 8'h12};
        send_value();
    endtask

    task automatic test_list_endings();
        set_list_mode(1'b1);
        value_bytes = '{8'h61, 8'h00, 8'h00, 8'h7A};
        send_value();
        value_bytes = '{8'h61, 8'h62};
        send_value();
        value_bytes = '{8'h00, 8'h00, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_value();
    endtask

    task automatic test_random_values(bit mode, int count, bit idle);
        int start;
        set_list_mode(mode);
        tx_idle_en = idle;
        rx_idle_en = idle;
        start = items_sent;
        while (items_sent - start < count) begin
            build_random_value();
            send_value();
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        value_bytes.delete();
        push_unit(16'h0041);
        repeat (24) push_unit(16'($urandom_range(16'h0800, 16'hFFFF)));
        send_value();
    endtask

    initial begin
        m_list = 1'b0;
        clear_decode();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_string();
        test_utf16_units();
        test_list_endings();
        test_random_values(1'b0, 120, 1'b1);
        test_random_values(1'b1, 120, 1'b1);
        test_backpressure();
        test_random_values(1'b0, 75, 1'b0);
        test_random_values(1'b1, 75, 1'b0);

        i_in_valid <= 1'b0;
        while (utf8_expected.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("** utf16le_string_list_to_utf8: PASSED **");
        end else begin
            $display("** utf16le_string_list_to_utf8: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_fifo.sv
rtl/u16u8_back.sv
rtl/utf16le_string_list_to_utf8.sv
rtl/u16u8_chk.sv
tb/testbench.sv
